@@ rtl/core/rgbhsl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared widths and the beat carried along the divider cell row.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

	localparam int unsigned CH_W    = 8;   // colour channel
	localparam int unsigned HUE_W   = 9;   // hue degrees, also quotient bits per row
	localparam int unsigned PCT_W   = 7;   // percent fields
	localparam int unsigned SUM_W   = 9;   // max + min
	localparam int unsigned HNUM_W  = 17;  // 60 * hue numerator
	localparam int unsigned SNUM_W  = 15;  // 100 * (max - min)
	localparam int unsigned CMP_W   = 17;  // compare width inside a cell
	localparam int unsigned N_CELLS = HUE_W;

	localparam logic [SUM_W-1:0] HALF_SUM = SUM_W'(255);
	localparam logic [SUM_W-1:0] FULL_SUM = SUM_W'(510);

	typedef struct packed {
		logic [HNUM_W-1:0] hue_rem;
		logic [CH_W-1:0]   hue_den;
		logic [HUE_W-1:0]  hue_q;
		logic [SNUM_W-1:0] sat_rem;
		logic [SUM_W-1:0]  sat_den;
		logic [HUE_W-1:0]  sat_q;
		logic              grey;
		logic [PCT_W-1:0]  light;
		logic              dark;
	} cell_t;

endpackage
`default_nettype wire

@@ rtl/core/rgbhsl_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsl_front
// Two stages: max/min and hue sector, then numerators, divisors and lightness.
// ----------------------------------------------------------------------------
module rgbhsl_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [7:0]                red,
	input  wire logic [7:0]                green,
	input  wire logic [7:0]                blue,
	input  wire logic [7:0]                alpha,
	output logic                           out_valid,
	output rgbhsl_pkg::cell_t              out_beat
);
	import rgbhsl_pkg::*;

	typedef enum logic [1:0] {
		SEC_BLUE,
		SEC_GREEN,
		SEC_RED_POS,
		SEC_RED_NEG
	} sector_t;

	// stage 1
	logic [CH_W-1:0]  mx, mn;
	logic [SUM_W-1:0] sum;
	sector_t          sec;
	logic [CH_W:0]    diff;

	logic             valid_s1;
	logic [CH_W-1:0]  d_s1;
	logic [SUM_W-1:0] sum_s1;
	sector_t          sec_s1;
	logic [CH_W:0]    diff_s1;
	logic             dark_s1;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		sum = {1'b0, mx} + {1'b0, mn};
		// blue beats green beats red on a tied maximum
		if (blue == mx) begin
			sec  = SEC_BLUE;
			diff = {1'b0, red} - {1'b0, green};
		end else if (green == mx) begin
			sec  = SEC_GREEN;
			diff = {1'b0, blue} - {1'b0, red};
		end else if (green >= blue) begin
			sec  = SEC_RED_POS;
			diff = {1'b0, green} - {1'b0, blue};
		end else begin
			sec  = SEC_RED_NEG;
			diff = {1'b0, blue} - {1'b0, green};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		d_s1    <= mx - mn;
		sum_s1  <= sum;
		sec_s1  <= sec;
		diff_s1 <= diff;
		dark_s1 <= (sum >= HALF_SUM) || (alpha == '0);
	end

	// stage 2
	logic [11:0]       dext, xext, v;
	logic [10:0]       v11;
	logic [HNUM_W-1:0] hnum;
	logic [SNUM_W-1:0] snum, lx, lsum;
	logic [SUM_W-1:0]  den;

	always_comb begin
		dext = {4'b0, d_s1};
		xext = {{3{diff_s1[CH_W]}}, diff_s1};
		case (sec_s1)
			SEC_BLUE:    v = (dext << 2) + xext;
			SEC_GREEN:   v = (dext << 1) + xext;
			SEC_RED_POS: v = xext;
			SEC_RED_NEG: v = (dext << 2) + (dext << 1) - xext;
			default:     v = '0;
		endcase
		v11  = v[10:0];
		hnum = (HNUM_W'(v11) << 6) - (HNUM_W'(v11) << 2);
		snum = (SNUM_W'(d_s1) << 6) + (SNUM_W'(d_s1) << 5) + (SNUM_W'(d_s1) << 2);
		den  = (sum_s1 < HALF_SUM) ? sum_s1 : FULL_SUM - sum_s1;
		// 50*s/255 by reciprocal, exact while the quotient stays at or below 100
		lx   = (SNUM_W'(sum_s1) << 5) + (SNUM_W'(sum_s1) << 4) + (SNUM_W'(sum_s1) << 1);
		lsum = lx + (lx >> 8) + SNUM_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_beat.hue_rem <= hnum;
		out_beat.hue_den <= d_s1;
		out_beat.hue_q   <= '0;
		out_beat.sat_rem <= snum;
		out_beat.sat_den <= den;
		out_beat.sat_q   <= '0;
		out_beat.grey    <= (d_s1 == '0);
		out_beat.light   <= lsum[14:8];
		out_beat.dark    <= dark_s1;
	end

endmodule
`default_nettype wire

@@ rtl/core/rgbhsl_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsl_cell
// One restoring-division step for hue and saturation; one quotient bit each.
// ----------------------------------------------------------------------------
module rgbhsl_cell #(
	parameter int unsigned BIT = 0
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire rgbhsl_pkg::cell_t         in_beat,
	output logic                           out_valid,
	output rgbhsl_pkg::cell_t              out_beat
);
	import rgbhsl_pkg::*;

	logic [CMP_W-1:0] hsh, ssh, hr, sr;
	logic             hb, sb;
	cell_t            nxt;

	always_comb begin
		hsh = CMP_W'(in_beat.hue_den) << BIT;
		ssh = CMP_W'(in_beat.sat_den) << BIT;
		hr  = CMP_W'(in_beat.hue_rem);
		sr  = CMP_W'(in_beat.sat_rem);
		hb  = (hr >= hsh);
		sb  = (sr >= ssh);
		if (hb) hr = hr - hsh;
		if (sb) sr = sr - ssh;
		nxt         = in_beat;
		nxt.hue_rem = hr[HNUM_W-1:0];
		nxt.sat_rem = sr[SNUM_W-1:0];
		nxt.hue_q   = {in_beat.hue_q[HUE_W-2:0], hb};
		nxt.sat_q   = {in_beat.sat_q[HUE_W-2:0], sb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_beat <= nxt;
	end

endmodule
`default_nettype wire

@@ rtl/core/rgb_to_hsl_converter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// RGBA pixel to hue degrees, saturation and lightness percent, overlay flag.
// ----------------------------------------------------------------------------
// Pipeline: two front stages plus nine divider cells, one quotient bit per cell,
//   from the start beat to the done strobe.
// Throughput: one pixel per clock; busy is always low and the result stream
//   is never stalled.
// Reset: arst_n clears all valid flags; data registers are not reset.
module rgb_to_hsl_converter (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	input  wire logic [7:0] alpha,
	output logic            done,
	output logic [8:0]      hue_degrees,
	output logic [6:0]      saturation_percent,
	output logic [6:0]      lightness_percent,
	output logic            dark_overlay
);
	import rgbhsl_pkg::*;

	logic  valid_c [0:N_CELLS];
	cell_t beat_c  [0:N_CELLS];

	assign busy = 1'b0;

	rgbhsl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha),
		.out_valid (valid_c[0]),
		.out_beat  (beat_c[0])
	);

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		rgbhsl_cell #(
			.BIT (N_CELLS - 1 - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_beat   (beat_c[i]),
			.out_valid (valid_c[i+1]),
			.out_beat  (beat_c[i+1])
		);
	end

	// grey pixel: both divisors may be zero, force hue and saturation to 0
	assign done               = valid_c[N_CELLS];
	assign hue_degrees        = beat_c[N_CELLS].grey ? '0 : beat_c[N_CELLS].hue_q;
	assign saturation_percent = beat_c[N_CELLS].grey ? '0 : beat_c[N_CELLS].sat_q[PCT_W-1:0];
	assign lightness_percent  = beat_c[N_CELLS].light;
	assign dark_overlay       = beat_c[N_CELLS].dark;

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##11 done) else $error("start beat did not reach done");
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##11 !done) else $error("done without start beat");
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hue_degrees < 9'd360) && (saturation_percent <= 7'd100)
			&& (lightness_percent <= 7'd100)) else $error("result out of range");
	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (lightness_percent >= 7'd50)) |-> dark_overlay)
		else $error("light pixel without dark overlay");
`endif

endmodule
`default_nettype wire

@@ test/rgb_to_hsl_converter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_tb
// Drives RGBA pixels through the converter and checks every result beat
// against an integer HSL calculation kept in the bench, in arrival order.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_tb;

	import rgbhsl_pkg::*;

	typedef struct {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] sat;
		logic [PCT_W-1:0] light;
		logic             dark;
	} hsl_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [CH_W-1:0]   red;
	logic [CH_W-1:0]   green;
	logic [CH_W-1:0]   blue;
	logic [CH_W-1:0]   alpha;
	logic              done;
	logic [HUE_W-1:0]  hue_degrees;
	logic [PCT_W-1:0]  saturation_percent;
	logic [PCT_W-1:0]  lightness_percent;
	logic              dark_overlay;

	hsl_t pending_hsl[$];
	int   error_count;

	rgb_to_hsl_converter u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.red                (red),
		.green              (green),
		.blue               (blue),
		.alpha              (alpha),
		.done               (done),
		.hue_degrees        (hue_degrees),
		.saturation_percent (saturation_percent),
		.lightness_percent  (lightness_percent),
		.dark_overlay       (dark_overlay)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Exact floors of the rational HSL values, integer arithmetic only.
	function automatic hsl_t pixel_to_hsl(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b, logic [CH_W-1:0] a);
		hsl_t res;
		int   ri;
		int   gi;
		int   bi;
		int   mx;
		int   mn;
		int   sum;
		int   diff;
		int   num;
		ri = int'(r);
		gi = int'(g);
		bi = int'(b);
		mx = ri;
		mn = ri;
		if (gi > mx) mx = gi;
		if (bi > mx) mx = bi;
		if (gi < mn) mn = gi;
		if (bi < mn) mn = bi;
		sum  = mx + mn;
		diff = mx - mn;
		res.light = PCT_W'((100 * sum) / 510);
		res.dark  = (sum >= 255) || (a == '0);
		res.hue   = '0;
		res.sat   = '0;
		if (diff != 0) begin
			if (sum < 255)
				res.sat = PCT_W'((100 * diff) / sum);
			else
				res.sat = PCT_W'((100 * diff) / (510 - sum));
			// blue beats green beats red on a tied maximum
			if (bi == mx)
				num = 60 * (4 * diff + ri - gi);
			else if (gi == mx)
				num = 60 * (2 * diff + bi - ri);
			else if (gi >= bi)
				num = 60 * (gi - bi);
			else
				num = 360 * diff - 60 * (bi - gi);  // wraps negative hue
			res.hue = HUE_W'(num / diff);
		end
		return res;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("%0t ns: %s mismatch, got %0d expected %0d", $time, field, got, want);
		error_count++;
	endtask

	// Accepted start beats queue a prediction; done beats are checked in order.
	always @(posedge clk) begin
		hsl_t want;
		if (done) begin
			if (pending_hsl.size() == 0) begin
				$display("%0t ns: result beat with nothing outstanding", $time);
				error_count++;
			end else begin
				want = pending_hsl.pop_front();
				if (hue_degrees !== want.hue)
					report_mismatch("hue_degrees", int'(hue_degrees), int'(want.hue));
				if (saturation_percent !== want.sat)
					report_mismatch("saturation_percent", int'(saturation_percent),
						int'(want.sat));
				if (lightness_percent !== want.light)
					report_mismatch("lightness_percent", int'(lightness_percent),
						int'(want.light));
				if (dark_overlay !== want.dark)
					report_mismatch("dark_overlay", int'(dark_overlay), int'(want.dark));
			end
		end
		if (arst_n && start && !busy)
			pending_hsl.push_back(pixel_to_hsl(red, green, blue, alpha));
	end

	task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b, logic [CH_W-1:0] a);
		start <= 1'b1;
		red   <= r;
		green <= g;
		blue  <= b;
		alpha <= a;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 3)) @(posedge clk);
	endtask

	// Random pixel biased towards greys, tied maxima, the half-lightness edge
	// and transparent alpha.
	task automatic send_random_pixel();
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] a;
		int              hi;
		r = CH_W'($urandom);
		g = CH_W'($urandom);
		b = CH_W'($urandom);
		a = ($urandom_range(0, 7) == 0) ? '0 : CH_W'($urandom);
		case ($urandom_range(0, 9))
			0: begin
				g = r;
				b = r;
			end
			1: g = r;
			2: b = g;
			3: b = r;
			4: begin
				// max + min lands on or beside 255
				hi = $urandom_range(128, 255);
				r  = CH_W'(hi);
				g  = CH_W'(255 - hi + $urandom_range(0, 2) - 1 + ((hi == 255) ? 1 : 0));
				b  = CH_W'($urandom_range(g, r));
			end
			5: begin
				r = 8'hFF;
				g = CH_W'($urandom_range(0, 3));
				b = CH_W'($urandom_range(0, 3));
			end
			default: ;
		endcase
		send_pixel(r, g, b, a);
	endtask

	task automatic test_directed_pixels();
		logic [4*CH_W-1:0] corner[] = '{
			32'h000000FF, 32'hFFFFFFFF, 32'hFFFFFF00, 32'h80808001,
			32'hFF0000FF, 32'h00FF00C8, 32'h0000FF64, 32'hFFFF00FF,
			32'h00FFFFFF, 32'hFF00FFFF, 32'hFF0001FF, 32'hC80A644D,
			32'h807F7FFF, 32'h7F7F8010, 32'hC83636FF, 32'h010000FF,
			32'hFEFFFFFF, 32'hAA5500FF, 32'h55AA55AA, 32'hAA55AA55,
			32'h00000100, 32'h01010180, 32'h00FF0100, 32'h7F0000FF
		};
		foreach (corner[i])
			send_pixel(corner[i][31:24], corner[i][23:16], corner[i][15:8], corner[i][7:0]);
		idle_burst();
	endtask

	task automatic test_random_pixels(int count);
		int idle_pct;
		idle_pct = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0)
				idle_pct = 25 * $urandom_range(0, 2);
			send_random_pixel();
			if ($urandom_range(0, 99) < idle_pct)
				idle_burst();
		end
	endtask

	task automatic test_back_to_back(int count);
		for (int i = 0; i < count; i++)
			send_random_pixel();
		start <= 1'b0;
	endtask

	initial begin
		error_count = 0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		red    <= '0;
		green  <= '0;
		blue   <= '0;
		alpha  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_pixels();
		test_random_pixels(1200);
		test_back_to_back(330);

		while (pending_hsl.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_hsl.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#1ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/rgbhsl_pkg.sv
rtl/core/rgbhsl_front.sv
rtl/core/rgbhsl_cell.sv
rtl/core/rgb_to_hsl_converter.sv
test/rgb_to_hsl_converter_tb.sv
